[rtl/core/pssr_pkg.sv]
// Shared types, constants and helpers for the projected sphere scissor rect block.
`timescale 1ns / 1ps
package pssr_pkg;

  localparam int MAX_PROXIES = 64;
  localparam int FRAC_BITS   = 16;
  localparam int SEEN_W      = $clog2(MAX_PROXIES + 1);

  localparam int VAL_W  = 32;
  localparam int PIX_W  = 14;
  localparam int DIM_W  = 31;
  localparam int SW     = 50;
  localparam int MUL_W  = 34;
  localparam int PROD_W = 2 * MUL_W;
  localparam int DVD_W  = 48;
  localparam int DVS_W  = 34;
  localparam int SQ_STEPS = 32;

  localparam int N_MATRIX = 16;
  localparam int N_PROXY  = 18;

  localparam int IN_TDATA_W  = VAL_W;
  localparam int IN_TUSER_W  = 7;
  localparam int OUT_TDATA_W = 8 * PIX_W;

  localparam int P_AXIS0   = 3;
  localparam int P_TERMS_X = 12;
  localparam int P_TERMS_Y = 13;
  localparam int P_TERMS_Z = 14;
  localparam int P_TERMS_W = 15;
  localparam int P_MOTION  = 16;
  localparam int P_SHAPE   = 17;

  localparam logic [PIX_W-1:0] WIDTH_RST  = 14'd1920;
  localparam logic [PIX_W-1:0] HEIGHT_RST = 14'd1080;
  localparam logic [DIM_W-1:0] NEAR_RST   = 31'd6554;
  localparam logic [DIM_W-1:0] SCALE_RST  = 31'd66191;

  typedef logic signed [VAL_W-1:0] val_t;
  typedef logic signed [SW-1:0]    wide_t;

  typedef enum logic [1:0] {
    REQ_MATRIX = 2'd0,
    REQ_PROXY  = 2'd1,
    REQ_EVAL   = 2'd2,
    REQ_FINISH = 2'd3
  } req_t;

  typedef enum logic [1:0] {
    CFG_WIDTH  = 2'd0,
    CFG_HEIGHT = 2'd1,
    CFG_NEAR   = 2'd2,
    CFG_SCALE  = 2'd3
  } cfg_idx_t;

  function automatic val_t sat32(input wide_t v);
    if (&v[SW-1:VAL_W-1] || ~|v[SW-1:VAL_W-1]) return v[VAL_W-1:0];
    else if (v[SW-1]) return {1'b1, {(VAL_W-1){1'b0}}};
    else return {1'b0, {(VAL_W-1){1'b1}}};
  endfunction

endpackage

[rtl/core/pssr_mul.sv]
// Bit-serial signed shift-add multiplier, one multiplier bit per cycle.
`timescale 1ns / 1ps
module pssr_mul (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                mul_go,
  input  logic signed [pssr_pkg::MUL_W-1:0]   mul_a,
  input  logic signed [pssr_pkg::MUL_W-1:0]   mul_b,
  output logic signed [pssr_pkg::PROD_W-1:0]  mul_prod,
  output logic                                mul_done
);
  import pssr_pkg::*;

  localparam int CNT_W = $clog2(MUL_W);

  logic signed [PROD_W-1:0] acc_r, mcand_r, acc_nxt, addend;
  logic [MUL_W-1:0]         mplier_r;
  logic [CNT_W-1:0]         cnt_r;
  logic                     busy_r, done_r;

  always_comb begin
    // top multiplier bit carries negative weight
    addend  = (cnt_r == CNT_W'(MUL_W - 1)) ? -mcand_r : mcand_r;
    acc_nxt = mplier_r[0] ? acc_r + addend : acc_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (mul_go) begin
        busy_r   <= 1'b1;
        cnt_r    <= '0;
        acc_r    <= '0;
        mcand_r  <= PROD_W'(mul_a);
        mplier_r <= mul_b;
      end else if (busy_r) begin
        acc_r    <= acc_nxt;
        mcand_r  <= mcand_r <<< 1;
        mplier_r <= mplier_r >> 1;
        cnt_r    <= cnt_r + 1'b1;
        if (cnt_r == CNT_W'(MUL_W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign mul_prod = acc_r;
  assign mul_done = done_r;

endmodule

[rtl/core/pssr_div.sv]
// Restoring unsigned divider, one quotient bit per cycle.
`timescale 1ns / 1ps
module pssr_div (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        div_go,
  input  logic [pssr_pkg::DVD_W-1:0]  div_num,
  input  logic [pssr_pkg::DVS_W-1:0]  div_den,
  output logic [pssr_pkg::DVD_W-1:0]  div_quo,
  output logic                        div_rem_nz,
  output logic                        div_done
);
  import pssr_pkg::*;

  localparam int CNT_W = $clog2(DVD_W);

  logic [DVD_W-1:0] quo_r;
  logic [DVS_W-1:0] rem_r, den_r;
  logic [DVS_W:0]   trial, diff;
  logic             fits;
  logic [CNT_W-1:0] cnt_r;
  logic             busy_r, done_r;

  always_comb begin
    trial = {rem_r, quo_r[DVD_W-1]};
    diff  = trial - {1'b0, den_r};
    fits  = trial >= {1'b0, den_r};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (div_go) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
        rem_r  <= '0;
        quo_r  <= div_num;
        den_r  <= div_den;
      end else if (busy_r) begin
        rem_r <= fits ? diff[DVS_W-1:0] : trial[DVS_W-1:0];
        quo_r <= {quo_r[DVD_W-2:0], fits};
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == CNT_W'(DVD_W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign div_quo    = quo_r;
  assign div_rem_nz = |rem_r;
  assign div_done   = done_r;

endmodule

[rtl/core/projected_sphere_scissor_rects_top.sv]
// Top level: request decode, proxy evaluation sequencer and rect accumulation.
//
// Load and finish beats are taken directly in the idle state. An evaluate beat is worked
// through a sequencer around a bit-serial multiplier, a bit-serial divider and a
// two-bits-per-cycle square root: first radius and displacement, then each of the
// 16 projected corners (9 products and two multiply-divide pairs); a corner at the
// near plane ends the evaluation at once, and a skipped evaluate leaves the block
// idle. A finish beat, like every beat, is taken only in the idle state, and waits
// while an earlier result is still held at the output and not taken.
`timescale 1ns / 1ps
module projected_sphere_scissor_rects_top (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   in_tvalid,
  output logic                                   in_tready,
  input  logic [pssr_pkg::IN_TDATA_W-1:0]        in_tdata,   // value
  input  logic [pssr_pkg::IN_TUSER_W-1:0]        in_tuser,   // req_type, slot
  output logic                                   out_tvalid,
  input  logic                                   out_tready,
  // scissor_x0, scissor_y0, scissor_x1, scissor_y1, copy_x0, copy_y0, copy_x1, copy_y1
  output logic [pssr_pkg::OUT_TDATA_W-1:0]       out_tdata,
  output logic [0:0]                             out_tuser,  // full_screen
  input  logic                                   cfg_valid,
  output logic                                   cfg_ready,
  input  logic [1:0]                             cfg_index,
  input  logic [31:0]                            cfg_data
);
  import pssr_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE, S_SQ_ISSUE, S_SQ_WAIT, S_SQRT_RUN, S_RAD_ISSUE, S_RAD_WAIT,
    S_MOT_A, S_MOT_ISSUE, S_MOT_WAIT, S_INNER, S_DISP_ISSUE, S_DISP_WAIT,
    S_RAD2, S_CL_ISSUE, S_CL_WAIT, S_CL_ROW, S_NEAR, S_DN_WAIT, S_DD_ISSUE,
    S_DD_WAIT, S_DD_UPD, S_RECT
  } state_t;

  state_t state_r;

  logic [PIX_W-1:0] frame_width_r, frame_height_r;
  logic [DIM_W-1:0] near_plane_r, mesh_scale_r;

  val_t matrix_r [N_MATRIX];
  val_t proxy_r  [N_PROXY];
  val_t scis_r [4];
  val_t copy_r [4];
  val_t srect_r [4];
  logic              near_hit_r;
  logic [SEEN_W-1:0] seen_r;

  logic                      mul_go_r, mul_done;
  logic signed [MUL_W-1:0]   mul_a_r, mul_b_r;
  logic signed [PROD_W-1:0]  mul_prod;
  logic                      div_go_r, div_done, div_rem_nz;
  logic [DVD_W-1:0]          div_num_r, div_quo;
  logic [DVS_W-1:0]          div_den_r;

  logic [1:0]  axis_r, k_r, row_r, step_r;
  logic [2:0]  corner_r;
  logic        sphere_r, yax_r, num_neg_r;
  logic [4:0]  sq_cnt_r;
  logic [63:0] sq_sum_r, sq_rad_r;
  logic [33:0] sq_rem_r;
  logic [31:0] sq_root_r, len_r;
  val_t        rad_r, rad2_r, disp_r, inner_r, cx_r, cy_r, cw_r;
  wide_t       acc_r, clacc_r, fl_r, ce_r, lox_r, loy_r, hix_r, hiy_r;
  logic [DVD_W-1:0] num_r;

  logic        out_valid_r, out_fs_r;
  logic [OUT_TDATA_W-1:0] out_data_r;

  req_t        in_req;
  logic [4:0]  in_slot;
  logic        in_acc;
  logic [1:0]  rowsel;
  logic [3:0]  mat_idx;
  logic [4:0]  proxy_idx;
  val_t        matrix_rd, proxy_rd, radsel, pc, rowv;
  wide_t       pw, pabs, shifted, inner_term, inner_nxt, disp3, qw, rz, fl, ce;
  logic [63:0] sum_nxt;
  logic [35:0] sq_trial, sq_sub;
  logic        sq_fit;
  logic [31:0] root_nxt;
  logic [33:0] rem_nxt;
  val_t        rect [4];
  logic        near_bad;
  logic [PIX_W-1:0] fin [8];

  function automatic logic [PIX_W-1:0] clampv(input val_t v, input logic [PIX_W-1:0] lim);
    if (v[VAL_W-1]) return '0;
    else if (v > $signed({{(VAL_W-PIX_W){1'b0}}, lim})) return lim;
    else return v[PIX_W-1:0];
  endfunction

  pssr_mul u_mul (
    .clk      (clk),
    .rst_n    (rst_n),
    .mul_go   (mul_go_r),
    .mul_a    (mul_a_r),
    .mul_b    (mul_b_r),
    .mul_prod (mul_prod),
    .mul_done (mul_done)
  );

  pssr_div u_div (
    .clk        (clk),
    .rst_n      (rst_n),
    .div_go     (div_go_r),
    .div_num    (div_num_r),
    .div_den    (div_den_r),
    .div_quo    (div_quo),
    .div_rem_nz (div_rem_nz),
    .div_done   (div_done)
  );

  always_comb begin
    in_req    = req_t'(in_tuser[1:0]);
    in_slot   = in_tuser[6:2];
    in_tready = (state_r == S_IDLE) &&
                (in_req != REQ_FINISH || !out_valid_r || out_tready);
    in_acc    = in_tvalid && in_tready;

    rowsel  = (row_r == 2'd2) ? 2'd3 : row_r;
    mat_idx = (state_r == S_CL_ROW) ? {rowsel, 2'd3} : {rowsel, k_r};

    unique case (state_r)
      S_SQ_ISSUE:   proxy_idx = 5'(P_AXIS0 + 3 * axis_r + k_r);
      S_MOT_A:      proxy_idx = 5'(P_TERMS_Y);
      S_MOT_ISSUE:  proxy_idx = 5'(P_MOTION);
      S_INNER:      proxy_idx = (step_r == 2'd0) ? 5'(P_TERMS_X) :
                                (step_r == 2'd1) ? 5'(P_TERMS_Z) : 5'(P_SHAPE);
      S_DISP_ISSUE: proxy_idx = 5'(P_TERMS_W);
      S_CL_ISSUE:   proxy_idx = {3'b0, k_r};
      default:      proxy_idx = '0;
    endcase

    matrix_rd = matrix_r[mat_idx];
    proxy_rd  = proxy_r[proxy_idx];
    pw        = SW'(proxy_rd);
    pabs      = pw[SW-1] ? -pw : pw;

    shifted = SW'(mul_prod >>> FRAC_BITS);
    sum_nxt = sq_sum_r + mul_prod[63:0];

    sq_trial = {sq_rem_r, sq_rad_r[63:62]};
    sq_sub   = {2'b0, sq_root_r, 2'b01};
    sq_fit   = sq_trial >= sq_sub;
    root_nxt = {sq_root_r[30:0], sq_fit};
    rem_nxt  = sq_fit ? 34'(sq_trial - sq_sub) : sq_trial[33:0];

    inner_term = (step_r == 2'd2) ? (pw <<< 1) : pabs;
    inner_nxt  = acc_r + inner_term;
    disp3      = (SW'(disp_r) <<< 1) + SW'(disp_r);

    radsel = sphere_r ? rad2_r : rad_r;
    pc     = sat32(corner_r[k_r] ? pw + SW'(radsel) : pw - SW'(radsel));
    rowv   = sat32(clacc_r + SW'(matrix_rd));

    near_bad = cw_r[VAL_W-1] || (cw_r == '0) ||
               ({cw_r, 1'b0} < {2'b0, near_plane_r});

    qw = SW'(div_quo);
    rz = SW'(div_rem_nz);
    fl = num_neg_r ? -(qw + rz) : qw;
    ce = num_neg_r ? -qw : qw + rz;

    rect[0] = sat32(lox_r - 50'sd2);
    rect[1] = sat32(loy_r - 50'sd2);
    rect[2] = sat32(hix_r + 50'sd2);
    rect[3] = sat32(hiy_r + 50'sd2);

    for (int i = 0; i < 4; i++) begin
      fin[i]     = clampv(scis_r[i], i[0] ? frame_height_r : frame_width_r);
      fin[4 + i] = clampv(copy_r[i], i[0] ? frame_height_r : frame_width_r);
    end
    if (near_hit_r) begin
      fin[0] = '0;
      fin[1] = '0;
      fin[2] = frame_width_r;
      fin[3] = frame_height_r;
      fin[4] = '0;
      fin[5] = '0;
      fin[6] = frame_width_r;
      fin[7] = frame_height_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= S_IDLE;
      out_valid_r    <= 1'b0;
      near_hit_r     <= 1'b0;
      seen_r         <= '0;
      mul_go_r       <= 1'b0;
      div_go_r       <= 1'b0;
      frame_width_r  <= WIDTH_RST;
      frame_height_r <= HEIGHT_RST;
      near_plane_r   <= NEAR_RST;
      mesh_scale_r   <= SCALE_RST;
      for (int i = 0; i < 4; i++) begin
        scis_r[i] <= '0;
        copy_r[i] <= '0;
      end
    end else begin
      mul_go_r <= 1'b0;
      div_go_r <= 1'b0;

      if (cfg_valid) begin
        unique case (cfg_idx_t'(cfg_index))
          CFG_WIDTH:  frame_width_r  <= cfg_data[PIX_W-1:0];
          CFG_HEIGHT: frame_height_r <= cfg_data[PIX_W-1:0];
          CFG_NEAR:   near_plane_r   <= cfg_data[DIM_W-1:0];
          CFG_SCALE:  mesh_scale_r   <= cfg_data[DIM_W-1:0];
        endcase
      end

      // a finish taken in the same cycle reloads the output instead
      if (out_valid_r && out_tready && !(in_acc && in_req == REQ_FINISH))
        out_valid_r <= 1'b0;

      unique case (state_r)
        S_IDLE: begin
          if (in_acc) begin
            unique case (in_req)
              REQ_MATRIX: begin
                if (in_slot < 5'(N_MATRIX)) matrix_r[in_slot[3:0]] <= in_tdata;
              end
              REQ_PROXY: begin
                if (in_slot < 5'(N_PROXY)) proxy_r[in_slot] <= in_tdata;
              end
              REQ_EVAL: begin
                if (!near_hit_r && seen_r < SEEN_W'(MAX_PROXIES)) begin
                  axis_r   <= '0;
                  k_r      <= '0;
                  sq_sum_r <= '0;
                  len_r    <= '0;
                  state_r  <= S_SQ_ISSUE;
                end
              end
              REQ_FINISH: begin
                out_valid_r <= 1'b1;
                out_fs_r    <= near_hit_r;
                out_data_r  <= {fin[7], fin[6], fin[5], fin[4],
                                fin[3], fin[2], fin[1], fin[0]};
                near_hit_r  <= 1'b0;
                seen_r      <= '0;
                for (int i = 0; i < 4; i++) begin
                  scis_r[i] <= '0;
                  copy_r[i] <= '0;
                end
              end
            endcase
          end
        end
        S_SQ_ISSUE: begin
          mul_a_r  <= MUL_W'(proxy_rd);
          mul_b_r  <= MUL_W'(proxy_rd);
          mul_go_r <= 1'b1;
          state_r  <= S_SQ_WAIT;
        end
        S_SQ_WAIT: begin
          if (mul_done) begin
            sq_sum_r <= sum_nxt;
            if (k_r == 2'd2) begin
              sq_rad_r  <= sum_nxt;
              sq_rem_r  <= '0;
              sq_root_r <= '0;
              sq_cnt_r  <= '0;
              state_r   <= S_SQRT_RUN;
            end else begin
              k_r     <= k_r + 1'b1;
              state_r <= S_SQ_ISSUE;
            end
          end
        end
        S_SQRT_RUN: begin
          sq_rem_r  <= rem_nxt;
          sq_root_r <= root_nxt;
          sq_rad_r  <= sq_rad_r << 2;
          sq_cnt_r  <= sq_cnt_r + 1'b1;
          if (sq_cnt_r == 5'(SQ_STEPS - 1)) begin
            if (root_nxt > len_r) len_r <= root_nxt;
            if (axis_r == 2'd2) begin
              state_r <= S_RAD_ISSUE;
            end else begin
              axis_r   <= axis_r + 1'b1;
              k_r      <= '0;
              sq_sum_r <= '0;
              state_r  <= S_SQ_ISSUE;
            end
          end
        end
        S_RAD_ISSUE: begin
          mul_a_r  <= MUL_W'(len_r);
          mul_b_r  <= MUL_W'(mesh_scale_r);
          mul_go_r <= 1'b1;
          state_r  <= S_RAD_WAIT;
        end
        S_RAD_WAIT: begin
          if (mul_done) begin
            rad_r   <= sat32(shifted);
            state_r <= S_MOT_A;
          end
        end
        S_MOT_A: begin
          mul_a_r <= MUL_W'(pabs);
          state_r <= S_MOT_ISSUE;
        end
        S_MOT_ISSUE: begin
          mul_b_r  <= MUL_W'(proxy_rd);
          mul_go_r <= 1'b1;
          state_r  <= S_MOT_WAIT;
        end
        S_MOT_WAIT: begin
          if (mul_done) begin
            acc_r   <= shifted;
            step_r  <= '0;
            state_r <= S_INNER;
          end
        end
        S_INNER: begin
          acc_r  <= inner_nxt;
          step_r <= step_r + 1'b1;
          if (step_r == 2'd2) begin
            inner_r <= sat32(inner_nxt);
            state_r <= S_DISP_ISSUE;
          end
        end
        S_DISP_ISSUE: begin
          mul_a_r  <= MUL_W'(proxy_rd);
          mul_b_r  <= MUL_W'(inner_r);
          mul_go_r <= 1'b1;
          state_r  <= S_DISP_WAIT;
        end
        S_DISP_WAIT: begin
          if (mul_done) begin
            disp_r  <= sat32(shifted);
            state_r <= S_RAD2;
          end
        end
        S_RAD2: begin
          rad2_r   <= sat32(SW'(rad_r) + (disp3 >>> 1));
          sphere_r <= 1'b0;
          corner_r <= '0;
          row_r    <= '0;
          k_r      <= '0;
          clacc_r  <= '0;
          state_r  <= S_CL_ISSUE;
        end
        S_CL_ISSUE: begin
          mul_a_r  <= MUL_W'(matrix_rd);
          mul_b_r  <= MUL_W'(pc);
          mul_go_r <= 1'b1;
          state_r  <= S_CL_WAIT;
        end
        S_CL_WAIT: begin
          if (mul_done) begin
            clacc_r <= clacc_r + shifted;
            if (k_r == 2'd2) begin
              k_r     <= '0;
              state_r <= S_CL_ROW;
            end else begin
              k_r     <= k_r + 1'b1;
              state_r <= S_CL_ISSUE;
            end
          end
        end
        S_CL_ROW: begin
          if (row_r == 2'd0) cx_r <= rowv;
          else if (row_r == 2'd1) cy_r <= rowv;
          else cw_r <= rowv;
          clacc_r <= '0;
          if (row_r == 2'd2) begin
            state_r <= S_NEAR;
          end else begin
            row_r   <= row_r + 1'b1;
            state_r <= S_CL_ISSUE;
          end
        end
        S_NEAR: begin
          if (near_bad) begin
            near_hit_r <= 1'b1;
            seen_r     <= seen_r + 1'b1;
            state_r    <= S_IDLE;
          end else begin
            mul_a_r  <= MUL_W'(SW'(cx_r) + SW'(cw_r));
            mul_b_r  <= MUL_W'(frame_width_r);
            mul_go_r <= 1'b1;
            yax_r    <= 1'b0;
            state_r  <= S_DN_WAIT;
          end
        end
        S_DN_WAIT: begin
          if (mul_done) begin
            num_r     <= mul_prod[DVD_W-1:0];
            num_neg_r <= mul_prod[PROD_W-1];
            state_r   <= S_DD_ISSUE;
          end
        end
        S_DD_ISSUE: begin
          div_num_r <= num_neg_r ? -num_r : num_r;
          div_den_r <= {1'b0, cw_r, 1'b0};
          div_go_r  <= 1'b1;
          state_r   <= S_DD_WAIT;
        end
        S_DD_WAIT: begin
          if (div_done) begin
            fl_r    <= fl;
            ce_r    <= ce;
            state_r <= S_DD_UPD;
          end
        end
        S_DD_UPD: begin
          if (!yax_r) begin
            if (corner_r == '0 || fl_r < lox_r) lox_r <= fl_r;
            if (corner_r == '0 || ce_r > hix_r) hix_r <= ce_r;
            mul_a_r  <= MUL_W'(SW'(cw_r) - SW'(cy_r));
            mul_b_r  <= MUL_W'(frame_height_r);
            mul_go_r <= 1'b1;
            yax_r    <= 1'b1;
            state_r  <= S_DN_WAIT;
          end else begin
            if (corner_r == '0 || fl_r < loy_r) loy_r <= fl_r;
            if (corner_r == '0 || ce_r > hiy_r) hiy_r <= ce_r;
            if (corner_r == 3'd7) begin
              state_r <= S_RECT;
            end else begin
              corner_r <= corner_r + 1'b1;
              row_r    <= '0;
              k_r      <= '0;
              clacc_r  <= '0;
              state_r  <= S_CL_ISSUE;
            end
          end
        end
        S_RECT: begin
          if (!sphere_r) begin
            for (int i = 0; i < 4; i++) srect_r[i] <= rect[i];
            sphere_r <= 1'b1;
            corner_r <= '0;
            row_r    <= '0;
            k_r      <= '0;
            clacc_r  <= '0;
            state_r  <= S_CL_ISSUE;
          end else begin
            for (int i = 0; i < 2; i++) begin
              if (seen_r == '0 || srect_r[i] < scis_r[i]) scis_r[i] <= srect_r[i];
              if (seen_r == '0 || rect[i] < copy_r[i]) copy_r[i] <= rect[i];
              if (seen_r == '0 || srect_r[i+2] > scis_r[i+2]) scis_r[i+2] <= srect_r[i+2];
              if (seen_r == '0 || rect[i+2] > copy_r[i+2]) copy_r[i+2] <= rect[i+2];
            end
            seen_r  <= seen_r + 1'b1;
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign cfg_ready  = 1'b1;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_fs_r;

endmodule
